// ----- design/a64dp_pkg.sv -----
// Shared types and codes for the A64 data-processing-immediate execute block.
`timescale 1ns / 1ps

package a64dp_pkg;

  localparam int RegCount = 31;
  localparam int AddrW    = 5;
  localparam int DataW    = 64;

  localparam logic [AddrW-1:0] ZeroReg = 5'd31;

  // instruction classes
  localparam logic [2:0] CMD_ARITH = 3'd2;
  localparam logic [2:0] CMD_MOVE  = 3'd5;

  // add/sub opc bits
  localparam int OPC_SETF_BIT = 0;
  localparam int OPC_SUB_BIT  = 1;

  // wide move opc codes
  localparam logic [1:0] MOV_N   = 2'd0;
  localparam logic [1:0] MOV_BAD = 2'd1;
  localparam logic [1:0] MOV_Z   = 2'd2;
  localparam logic [1:0] MOV_K   = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDEF = 3'd1,
    ST_SP    = 3'd2,
    ST_SLICE = 3'd3,
    ST_OPC   = 3'd4
  } status_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } wr_req_t;

endpackage

// ----- design/a64dp_regfile.sv -----
// General register file: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps

module a64dp_regfile
  import a64dp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  wr_req_t          wr,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [DataW-1:0] rd_data
);

  logic [DataW-1:0] mem [RegCount];
  logic [RegCount-1:0] valid;

  logic [DataW-1:0] mem_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_q;
  logic             live_q;

  logic             rd_zero;
  logic             wr_ok;
  logic             hit;
  logic [AddrW-1:0] rd_idx;

  assign rd_zero = (rd_addr == ZeroReg);
  assign rd_idx  = rd_zero ? '0 : rd_addr;
  assign wr_ok   = wr.en && (wr.addr != ZeroReg);
  assign hit     = wr_ok && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q      <= mem[rd_idx];
      fwd_q      <= hit;
      fwd_data_q <= wr.data;
      live_q     <= valid[rd_idx] && !rd_zero;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : (live_q ? mem_q : '0);

endmodule

// ----- design/a64_data_processing_immediate.sv -----
// Top level: A64 add/sub immediate and wide move execute stage.
`timescale 1ns / 1ps
//
// Usage
//   s_* channel carries one decoded instruction per transfer; s_tuser is the
//   instruction class (2 add/sub immediate, 5 wide move), s_tdata the fields.
//   m_* channel returns one result per instruction: status, write flag,
//   destination, 64-bit value and the NZCV flags after the instruction.
//   An accepted transfer is held in the execute stage and then in the output
//   register, from which it leaves on m_*. Throughput: one instruction per
//   cycle, sustained while the receiver keeps m_tready high.
//   The register file read port is registered: the operand is read at
//   accept, the result is computed and written back as the instruction leaves
//   the execute stage, and a write to the entry being read in the same cycle is bypassed.
//   Reset (rst, synchronous): register file reads as zero (valid bits
//   cleared at once, no sweep), flags cleared, both stages emptied.
//   Receiver stall: the result waits in the output register; one more
//   instruction may be taken into the execute stage, then s_tready drops.
//
module a64_data_processing_immediate
  import a64dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // cmd
  input  logic [47:0] s_tdata,   // is_64, opc[2], imm_shift, imm12[12], half_sel[2],
                                 // imm16[16], src_reg[5], dst_reg[5], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // status[3], wrote, dest[5], value[64], nzcv[4], zero pad
);

  // input field unpack
  logic             in_is64;
  logic [1:0]       in_opc;
  logic             in_sh;
  logic [11:0]      in_imm12;
  logic [1:0]       in_hw;
  logic [15:0]      in_imm16;
  logic [AddrW-1:0] in_rn;
  logic [AddrW-1:0] in_rd;

  assign in_is64  = s_tdata[0];
  assign in_opc   = s_tdata[2:1];
  assign in_sh    = s_tdata[3];
  assign in_imm12 = s_tdata[15:4];
  assign in_hw    = s_tdata[17:16];
  assign in_imm16 = s_tdata[33:18];
  assign in_rn    = s_tdata[38:34];
  assign in_rd    = s_tdata[43:39];

  // execute stage
  logic             s1_valid;
  logic [2:0]       s1_cmd;
  logic             s1_is64;
  logic [1:0]       s1_opc;
  logic             s1_sh;
  logic [11:0]      s1_imm12;
  logic [1:0]       s1_hw;
  logic [15:0]      s1_imm16;
  logic [AddrW-1:0] s1_rn;
  logic [AddrW-1:0] s1_rd;

  logic [3:0] flags;
  logic [3:0] flags_next;

  logic accept;
  logic s1_advance;

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;

  // MOVK reads its destination, add/sub reads its source
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] opnd;
  wr_req_t          wr;

  assign rd_addr = (s_tuser == CMD_MOVE) ? in_rd : in_rn;

  a64dp_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (opnd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= s_tuser;
      s1_is64  <= in_is64;
      s1_opc   <= in_opc;
      s1_sh    <= in_sh;
      s1_imm12 <= in_imm12;
      s1_hw    <= in_hw;
      s1_imm16 <= in_imm16;
      s1_rn    <= in_rn;
      s1_rd    <= in_rd;
    end
  end

  // datapath
  logic [DataW-1:0] wmask;
  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic [DataW-1:0] bx;
  logic [DataW:0]   sum;
  logic [DataW-1:0] r;
  logic             sub;
  logic             setf;
  logic             fn;
  logic             fz;
  logic             fc;
  logic             fv;
  logic [DataW-1:0] ovf;
  logic [5:0]       mv_shift;
  logic [DataW-1:0] mv_op;
  logic [DataW-1:0] mv_keep;
  logic [DataW-1:0] mv_res;

  status_t          res_status;
  logic [DataW-1:0] res_value;
  logic             res_wrote;

  always_comb begin
    wmask = s1_is64 ? '1 : {32'd0, 32'hFFFF_FFFF};
    sub   = s1_opc[OPC_SUB_BIT];
    setf  = s1_opc[OPC_SETF_BIT];
    a     = opnd & wmask;
    b     = s1_sh ? {40'd0, s1_imm12, 12'd0} : {52'd0, s1_imm12};
    // subtract as a plus inverted b plus one
    bx    = (sub ? ~b : b) & wmask;
    sum   = {1'b0, a} + {1'b0, bx} + {{DataW{1'b0}}, sub};
    r     = sum[DataW-1:0] & wmask;
    ovf   = (a ^ r) & (bx ^ r);
    fn    = s1_is64 ? r[63] : r[31];
    fz    = (r == '0);
    fc    = s1_is64 ? sum[64] : sum[32];
    fv    = s1_is64 ? ovf[63] : ovf[31];

    mv_shift = {s1_hw, 4'b0000};
    mv_op    = {48'd0, s1_imm16} << mv_shift;
    mv_keep  = opnd & ~({48'd0, 16'hFFFF} << mv_shift);
    case (s1_opc)
      MOV_N:   mv_res = ~mv_op & wmask;
      MOV_Z:   mv_res = mv_op & wmask;
      MOV_K:   mv_res = (mv_keep | mv_op) & wmask;
      default: mv_res = '0;
    endcase

    res_status = ST_OK;
    res_value  = '0;
    flags_next = flags;
    case (s1_cmd)
      CMD_ARITH: begin
        if (s1_rn == ZeroReg || (s1_rd == ZeroReg && !setf)) begin
          res_status = ST_SP;
        end else begin
          res_value = r;
          if (setf) begin
            flags_next = {fn, fz, fc, fv};
          end
        end
      end
      CMD_MOVE: begin
        if (!s1_is64 && s1_hw[1]) begin
          res_status = ST_SLICE;
        end else if (s1_opc == MOV_BAD) begin
          res_status = ST_OPC;
        end else begin
          res_value = mv_res;
        end
      end
      default: res_status = ST_UNDEF;
    endcase

    // zero register destination: result reported, nothing stored
    res_wrote = (res_status == ST_OK) && (s1_rd != ZeroReg);

    wr.en   = s1_advance && res_wrote;
    wr.addr = s1_rd;
    wr.data = res_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_advance) begin
      flags <= flags_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= {3'd0, flags_next, res_value, (res_wrote ? s1_rd : ZeroReg ^ ZeroReg),
                  res_wrote, res_status};
    end
  end

endmodule

// ----- design/a64dp_checker.sv -----
// Port-level checks for the execute block, bound to the top level.
`timescale 1ns / 1ps

module a64dp_checker
  import a64dp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  logic [2:0]       o_status;
  logic             o_wrote;
  logic [AddrW-1:0] o_dest;
  logic [DataW-1:0] o_value;

  assign o_status = m_tdata[2:0];
  assign o_wrote  = m_tdata[3];
  assign o_dest   = m_tdata[8:4];
  assign o_value  = m_tdata[72:9];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_status != ST_OK |-> !o_wrote && o_value == '0 && o_dest == '0)
    else $error("failed instruction reported a write or value");

  a_no_zr_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_wrote |-> o_dest != ZeroReg)
    else $error("write reported to register 31");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind a64_data_processing_immediate a64dp_checker u_a64dp_checker (.*);

// ----- tb/sv/a64dp_exec_check.sv -----
// Checker for the A64 execute block: predicts each instruction's result and compares.
`timescale 1ns / 1ps

module a64dp_exec_check
  import a64dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [2:0]  s_tuser,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    status_t    status;
    logic       wrote;
    logic [4:0] dest;
    logic [63:0] value;
    logic [3:0] nzcv;
  } exec_result_t;

  logic [63:0]  gpr [0:RegCount-1];
  logic [3:0]   flags;
  exec_result_t expected_results[$];
  exec_result_t want;
  int           result_cnt;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
    $display("result %0d: %s mismatch, got %h, expected %h", result_cnt, what, got, exp_val);
    errors++;
  endtask

  function automatic logic [63:0] read_gpr(input logic [4:0] r, input logic w64);
    logic [63:0] v;
    v = (r == ZeroReg) ? 64'h0 : gpr[r];
    return w64 ? v : {32'h0, v[31:0]};
  endfunction

  // Executes one instruction on the shadow register file and flags.
  function automatic exec_result_t execute(input logic [2:0] cmd, input logic [47:0] f);
    logic         w64, sh, setf, sub, carry, ok;
    logic [1:0]   opc, hw;
    logic [11:0]  imm12;
    logic [15:0]  imm16;
    logic [4:0]   rn, rd;
    logic [63:0]  mask, a, b, r, ovf, op, slice;
    int           msb;
    exec_result_t res;
    w64   = f[0];
    opc   = f[2:1];
    sh    = f[3];
    imm12 = f[15:4];
    hw    = f[17:16];
    imm16 = f[33:18];
    rn    = f[38:34];
    rd    = f[43:39];
    mask  = w64 ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
    msb   = w64 ? 63 : 31;
    res.status = ST_OK;
    res.wrote  = 1'b0;
    res.dest   = 5'd0;
    res.value  = 64'h0;
    ok = 1'b0;
    r  = 64'h0;
    if (cmd == CMD_ARITH) begin
      setf = opc[OPC_SETF_BIT];
      sub  = opc[OPC_SUB_BIT];
      if (rn == ZeroReg || (rd == ZeroReg && !setf)) begin
        res.status = ST_SP;
      end else begin
        a = read_gpr(rn, w64);
        b = sh ? {40'h0, imm12, 12'h0} : {52'h0, imm12};
        r = (sub ? a - b : a + b) & mask;
        if (setf) begin
          // C is not-borrow for subtraction, carry out for addition
          carry = sub ? (a >= b) : (r < a);
          ovf   = sub ? ((a ^ b) & (a ^ r)) : ((a ^ r) & (b ^ r));
          flags = {r[msb], r == 64'h0, carry, ovf[msb]};
        end
        ok = 1'b1;
      end
    end else if (cmd == CMD_MOVE) begin
      if (!w64 && hw > 2'd1) begin
        res.status = ST_SLICE;
      end else if (opc == MOV_BAD) begin
        res.status = ST_OPC;
      end else begin
        op    = {48'h0, imm16} << {hw, 4'b0};
        slice = 64'hFFFF << {hw, 4'b0};
        case (opc)
          MOV_N:   r = ~op & mask;
          MOV_Z:   r = op & mask;
          default: r = ((read_gpr(rd, w64) & ~slice) | op) & mask;
        endcase
        ok = 1'b1;
      end
    end else begin
      res.status = ST_UNDEF;
    end
    if (ok) begin
      res.value = r;
      if (rd != ZeroReg) begin
        gpr[rd]   = r;
        res.wrote = 1'b1;
        res.dest  = rd;
      end
    end
    res.nzcv = flags;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RegCount; i++) gpr[i] = 64'h0;
      flags = 4'h0;
      expected_results.delete();
    end else begin
      // results first: a result never belongs to an instruction taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", m_tdata[72:9], 64'h0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[2:0] !== want.status)
            report("status", 64'(m_tdata[2:0]), 64'(want.status));
          if (m_tdata[3] !== want.wrote)
            report("wrote", 64'(m_tdata[3]), 64'(want.wrote));
          if (m_tdata[8:4] !== want.dest)
            report("dest", 64'(m_tdata[8:4]), 64'(want.dest));
          if (m_tdata[72:9] !== want.value) report("value", m_tdata[72:9], want.value);
          if (m_tdata[76:73] !== want.nzcv)
            report("nzcv", 64'(m_tdata[76:73]), 64'(want.nzcv));
        end
        result_cnt++;
      end
      if (s_tvalid && s_tready) expected_results.push_back(execute(s_tuser, s_tdata));
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the A64 add/sub immediate and wide move execute block.
`timescale 1ns / 1ps

module tb
  import a64dp_pkg::*;
;

  // add/sub immediate opc codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_ADDS = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_SUBS = 2'd3;

  localparam int ITEMS = 1550;

  // receiver behavior, one per phase
  typedef enum logic [1:0] {
    SINK_OPEN,    // always ready
    SINK_COIN,    // ready half the time
    SINK_SPARSE,  // ready one cycle in four
    SINK_HOLD     // stalled for most of the phase, then drains
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [2:0]  s_tuser = 3'd0;
  logic [47:0] s_tdata = 48'h0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  int          errors;
  int          outstanding;
  int          sent;
  int          burst_left;
  int          next_drain;
  int          phase_left;
  sink_mode_t  sink_mode = SINK_OPEN;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  a64_data_processing_immediate dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a64dp_exec_check u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Receiver: picks a stall mode per phase of random length. The hold mode
  // backs the pipeline up so the sender sees s_tready drop.
  always @(posedge clk) begin
    if (phase_left == 0) begin
      sink_mode  <= sink_mode_t'($urandom_range(0, 3));
      phase_left <= int'($urandom_range(20, 100));
    end else begin
      phase_left <= phase_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   m_tready <= 1'b1;
      SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:     m_tready <= (phase_left < 8);
    endcase
  end

  // Instruction fields into s_tdata, lowest bit first:
  // is_64, opc, imm_shift, imm12, half_sel, imm16, src_reg, dst_reg, zero pad.
  function automatic logic [47:0] pack(input logic w64, input logic [1:0] opc,
                                       input logic sh, input logic [11:0] imm12,
                                       input logic [1:0] hw, input logic [15:0] imm16,
                                       input logic [4:0] rn, input logic [4:0] rd);
    return {4'h0, rd, rn, imm16, hw, imm12, sh, opc, w64};
  endfunction

  // Registers mostly from a small pool so results feed later instructions;
  // the stack pointer / zero register shows up now and then.
  function automatic logic [4:0] pick_reg();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 5'($urandom_range(0, 7));
    if (roll == 7) return ZeroReg;
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [11:0] pick_imm12();
    case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'hFFF;
      2:       return 12'h001;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [15:0] pick_imm16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One transfer on the instruction channel. Bursts of random length with
  // random gaps in between; long bursts give stretches with no idle cycles.
  task automatic issue(input logic [2:0] cmd, input logic [47:0] fields);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= fields;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    logic       w64;
    logic [2:0] cmd;
    logic [1:0] opc, hw;
    logic [4:0] rd;
    int         sel;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // --- directed: flag corners on both widths ---
    issue(CMD_MOVE,  pack(1'b1, MOV_N,   1'b0, 12'h000, 2'd0, 16'h0000, 5'd0, 5'd1));  // x1 = ~0
    issue(CMD_ARITH, pack(1'b1, OP_ADDS, 1'b0, 12'h001, 2'd0, 16'h0000, 5'd1, 5'd2));  // carry
    issue(CMD_ARITH, pack(1'b1, OP_SUBS, 1'b0, 12'h001, 2'd0, 16'h0000, 5'd0, 5'd3));  // borrow
    issue(CMD_MOVE,  pack(1'b1, MOV_N,   1'b0, 12'h000, 2'd3, 16'h8000, 5'd0, 5'd4));  // max pos
    issue(CMD_ARITH, pack(1'b1, OP_ADDS, 1'b0, 12'h001, 2'd0, 16'h0000, 5'd4, 5'd5));  // overflow
    // flags only, result to the zero register; shifted immediate
    issue(CMD_ARITH, pack(1'b1, OP_SUBS, 1'b1, 12'hFFF, 2'd0, 16'h0000, 5'd5, ZeroReg));
    issue(CMD_MOVE,  pack(1'b0, MOV_Z,   1'b0, 12'h000, 2'd1, 16'h7FFF, 5'd0, 5'd6));
    issue(CMD_MOVE,  pack(1'b0, MOV_K,   1'b0, 12'h000, 2'd0, 16'hFFFF, 5'd0, 5'd6));
    issue(CMD_ARITH, pack(1'b0, OP_ADDS, 1'b0, 12'h001, 2'd0, 16'h0000, 5'd6, 5'd7));  // 32-bit ovf
    issue(CMD_ARITH, pack(1'b0, OP_ADD,  1'b1, 12'hFFF, 2'd0, 16'h0000, 5'd1, 5'd9));  // wraps
    issue(CMD_ARITH, pack(1'b1, OP_SUB,  1'b0, 12'hFFF, 2'd0, 16'h0000, 5'd0, 5'd10));
    issue(CMD_MOVE,  pack(1'b1, MOV_K,   1'b0, 12'h000, 2'd3, 16'hABCD, 5'd0, 5'd1));
    issue(CMD_MOVE,  pack(1'b1, MOV_K,   1'b0, 12'h000, 2'd2, 16'hFFFF, 5'd0, ZeroReg)); // reads 0
    issue(CMD_MOVE,  pack(1'b1, MOV_Z,   1'b0, 12'h000, 2'd3, 16'hFFFF, 5'd0, 5'd30));
    issue(CMD_MOVE,  pack(1'b0, MOV_N,   1'b0, 12'h000, 2'd1, 16'hFFFF, 5'd0, 5'd29));
    // error cases: slice too high, bad opc, and slice checked ahead of opc
    issue(CMD_MOVE,  pack(1'b0, MOV_Z,   1'b0, 12'h000, 2'd2, 16'h1234, 5'd0, 5'd11));
    issue(CMD_MOVE,  pack(1'b1, MOV_BAD, 1'b0, 12'h000, 2'd1, 16'h5555, 5'd0, 5'd12));
    issue(CMD_MOVE,  pack(1'b0, MOV_BAD, 1'b0, 12'h000, 2'd3, 16'hAAAA, 5'd0, 5'd12));
    // stack pointer as source or as ADD/SUB destination
    issue(CMD_ARITH, pack(1'b1, OP_ADD,  1'b0, 12'h005, 2'd0, 16'h0000, ZeroReg, 5'd13));
    issue(CMD_ARITH, pack(1'b1, OP_ADD,  1'b0, 12'h005, 2'd0, 16'h0000, 5'd1, ZeroReg));
    issue(CMD_ARITH, pack(1'b1, OP_SUB,  1'b0, 12'h005, 2'd0, 16'h0000, 5'd1, ZeroReg));
    // every undefined class value
    for (int c = 0; c < 8; c++) begin
      if (3'(c) != CMD_ARITH && 3'(c) != CMD_MOVE)
        issue(3'(c), pack(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), pick_imm12(),
                          2'($urandom_range(0, 3)), pick_imm16(), pick_reg(),
                          pick_reg()));
    end

    // --- random ---
    next_drain = 500;
    while (sent < ITEMS) begin
      // pressure: let the pipeline run dry now and then
      if (sent >= next_drain) begin
        drain();
        next_drain += 500;
      end
      if ($urandom_range(0, 4) == 0) begin
        // build a register slice by slice, then do arithmetic on it
        w64 = ($urandom_range(0, 3) != 0);
        rd  = 5'($urandom_range(0, 7));
        issue(CMD_MOVE, pack(w64, MOV_Z, 1'($urandom_range(0, 1)), pick_imm12(), 2'd0,
                             pick_imm16(), pick_reg(), rd));
        for (int h = 1; h <= (w64 ? 3 : 1); h++)
          issue(CMD_MOVE, pack(w64, MOV_K, 1'($urandom_range(0, 1)), pick_imm12(), 2'(h),
                               pick_imm16(), pick_reg(), rd));
        issue(CMD_ARITH, pack(w64, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              pick_imm12(), 2'($urandom_range(0, 3)), pick_imm16(), rd,
                              pick_reg()));
      end else begin
        sel = $urandom_range(0, 19);
        w64 = 1'($urandom_range(0, 1));
        opc = 2'($urandom_range(0, 3));
        hw  = 2'($urandom_range(0, 3));
        if (sel < 9) begin
          cmd = CMD_ARITH;
        end else if (sel < 18) begin
          cmd = CMD_MOVE;
          // keep most wide moves legal
          if (opc == MOV_BAD && $urandom_range(0, 3) != 0) opc = MOV_K;
          if (!w64 && $urandom_range(0, 4) != 0) hw = 2'($urandom_range(0, 1));
        end else begin
          cmd = 3'($urandom_range(0, 7));
        end
        issue(cmd, pack(w64, opc, 1'($urandom_range(0, 1)), pick_imm12(), hw, pick_imm16(),
                        pick_reg(), pick_reg()));
      end
    end

    drain();
    // catch any stray result after the last one expected
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("[a64_data_processing_immediate] OK");
    end else begin
      $display("[a64_data_processing_immediate] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[a64_data_processing_immediate] ERROR");
    $finish;
  end

endmodule
